@@ design/adaptive_jitter_buffer_defines.svh @@
// assertion macros for the adaptive jitter buffer
// no dependencies; included by the modules that carry assertions
`ifndef ADAPTIVE_JITTER_BUFFER_DEFINES_SVH
`define ADAPTIVE_JITTER_BUFFER_DEFINES_SVH
`ifndef SYNTHESIS
`define AJB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define AJB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define AJB_ASSERT(lbl, prop, msg)
`define AJB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ design/ajb_pkg.sv @@
// shared constants, codes and types for the adaptive jitter buffer
// no dependencies
`timescale 1ns / 1ps
package ajb_pkg;
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int SEQ_W = 16;
    localparam int TS_W = 32;
    localparam int HND_W = 16;
    localparam int LEN_W = 12;
    localparam int TIME_W = 47;
    localparam int DUE_W = 48;
    localparam int MS_W = 10;
    localparam int CNT_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int ENTRY_W = SEQ_W + TS_W + HND_W + LEN_W;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TARGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TARGET = 2'd2;

    localparam logic [2:0] RES_INSERTED = 3'd0;
    localparam logic [2:0] RES_EMPTY = 3'd1;
    localparam logic [2:0] RES_LATE = 3'd2;
    localparam logic [2:0] RES_NOT_DUE = 3'd3;
    localparam logic [2:0] RES_PLAYED = 3'd4;
    localparam logic [2:0] RES_CONCEALED = 3'd5;

    localparam logic [MS_W-1:0] FRAME_DEFAULT = 10'd20;
    localparam logic [MS_W-1:0] MIN_TARGET_RESET = 10'd60;
    localparam logic [MS_W-1:0] MAX_TARGET_RESET = 10'd180;
    localparam logic [15:0] EWMA_KEEP = 16'd62259;
    localparam logic [11:0] EWMA_GAIN = 12'd3277;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_EMPTY,
        OP_DROP,
        OP_FLUSH,
        OP_J1,
        OP_J2,
        OP_J3,
        OP_J4,
        OP_J5,
        OP_SCAN,
        OP_INS_COMMIT,
        OP_PLAY_READ,
        OP_PLAY_COMMIT,
        OP_CONCEAL,
        OP_LOAD_OUT
    } ajb_op_t;

    typedef struct packed {
        logic is_insert;
        logic is_tick;
        logic is_flush;
        logic len_zero;
        logic late;
        logic due;
        logic scan_done;
        logic hit;
    } ajb_flags_t;
endpackage

@@ design/ajb_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module ajb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/ajb_ctrl.sv @@
// controller state machine sequencing decode, jitter update, table scan and result
// depends on ajb_pkg
`timescale 1ns / 1ps
module ajb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  ajb_pkg::ajb_flags_t flags,
    output ajb_pkg::ajb_op_t   op
);
    import ajb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_J1, S_J2, S_J3, S_J4, S_J5,
        S_SCAN, S_INS, S_PLAY_SEL, S_PLAY_FIN, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        op = OP_NONE;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                if (flags.is_insert) begin
                    if (flags.len_zero) begin
                        op = OP_EMPTY;
                    end else if (flags.late) begin
                        op = OP_DROP;
                    end else begin
                        state_next = S_J1;
                    end
                end else if (flags.is_tick) begin
                    if (flags.due) begin
                        state_next = S_SCAN;
                    end
                end else if (flags.is_flush) begin
                    op = OP_FLUSH;
                end
            end
            S_J1: begin
                op = OP_J1;
                state_next = S_J2;
            end
            S_J2: begin
                op = OP_J2;
                state_next = S_J3;
            end
            S_J3: begin
                op = OP_J3;
                state_next = S_J4;
            end
            S_J4: begin
                op = OP_J4;
                state_next = S_J5;
            end
            S_J5: begin
                op = OP_J5;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                op = OP_SCAN;
                if (flags.scan_done) begin
                    state_next = flags.is_insert ? S_INS : S_PLAY_SEL;
                end
            end
            S_INS: begin
                op = OP_INS_COMMIT;
                state_next = S_DONE;
            end
            S_PLAY_SEL: begin
                if (flags.hit) begin
                    op = OP_PLAY_READ;
                    state_next = S_PLAY_FIN;
                end else begin
                    op = OP_CONCEAL;
                    state_next = S_DONE;
                end
            end
            S_PLAY_FIN: begin
                op = OP_PLAY_COMMIT;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    op = OP_LOAD_OUT;
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule

@@ design/ajb_dp.sv @@
// datapath: configuration, playout state, jitter estimator, entry table and result registers
// depends on ajb_pkg, ajb_ram and adaptive_jitter_buffer_defines.svh
`timescale 1ns / 1ps
`include "adaptive_jitter_buffer_defines.svh"
module ajb_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ajb_pkg::ajb_op_t              op,
    output ajb_pkg::ajb_flags_t           flags,
    input  logic                          cfg_valid,
    input  logic [ajb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ajb_pkg::MS_W-1:0]      cfg_data,
    input  logic [1:0]                    s_command,
    input  logic [ajb_pkg::SEQ_W-1:0]     s_seq,
    input  logic [ajb_pkg::TS_W-1:0]      s_timestamp,
    input  logic [ajb_pkg::HND_W-1:0]     s_payload_handle,
    input  logic [ajb_pkg::LEN_W-1:0]     s_payload_length,
    input  logic [ajb_pkg::TIME_W-1:0]    s_time_ms,
    output logic [2:0]                    m_status,
    output logic [ajb_pkg::SEQ_W-1:0]     m_seq_out,
    output logic [ajb_pkg::TS_W-1:0]      m_timestamp_out,
    output logic [ajb_pkg::HND_W-1:0]     m_payload_handle_out,
    output logic [ajb_pkg::LEN_W-1:0]     m_payload_length_out,
    output logic [ajb_pkg::MS_W-1:0]      m_target_ms,
    output logic [ajb_pkg::OCC_W-1:0]     m_depth,
    output logic [ajb_pkg::CNT_W-1:0]     m_late_drop_count,
    output logic [ajb_pkg::CNT_W-1:0]     m_inserted_count,
    output logic [ajb_pkg::CNT_W-1:0]     m_played_count,
    output logic [ajb_pkg::CNT_W-1:0]     m_lost_count
);
    import ajb_pkg::*;

    localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    // latched transaction
    logic [1:0]        in_cmd_reg;
    logic [SEQ_W-1:0]  in_seq_reg;
    logic [TS_W-1:0]   in_ts_reg;
    logic [HND_W-1:0]  in_hnd_reg;
    logic [LEN_W-1:0]  in_len_reg;
    logic [TIME_W-1:0] in_now_reg;

    logic [MS_W-1:0]   frame_reg, min_tgt_reg, max_tgt_reg;
    logic              started_reg, last_vld_reg;
    logic [SEQ_W-1:0]  exp_seq_reg;
    logic [TS_W-1:0]   exp_ts_reg;
    logic [DUE_W-1:0]  next_due_reg;
    logic [TIME_W-1:0] last_arr_reg;
    logic [31:0]       smooth_reg;
    logic [MS_W-1:0]   target_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  drop_reg, ins_reg, play_reg, loss_reg;

    logic [TIME_W-1:0] delta_reg;
    logic [15:0]       jit_reg;
    logic [47:0]       prod_a_reg;
    logic [27:0]       prod_b_reg;

    logic [IDX_W:0]    scan_idx_reg;
    logic              chk_vld_reg;
    logic [IDX_W-1:0]  chk_idx_reg;
    logic              hit_vld_reg, free_vld_reg, min_vld_reg;
    logic [IDX_W-1:0]  hit_idx_reg, free_idx_reg, min_idx_reg;
    logic [SEQ_W-1:0]  min_seq_reg;

    logic [2:0]        res_status_reg;
    logic [SEQ_W-1:0]  res_seq_reg;
    logic [TS_W-1:0]   res_ts_reg;
    logic [HND_W-1:0]  res_hnd_reg;
    logic [LEN_W-1:0]  res_len_reg;

    logic [2:0]        out_status_reg;
    logic [SEQ_W-1:0]  out_seq_reg;
    logic [TS_W-1:0]   out_ts_reg;
    logic [HND_W-1:0]  out_hnd_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic [MS_W-1:0]   out_target_reg;
    logic [OCC_W-1:0]  out_occ_reg;
    logic [CNT_W-1:0]  out_drop_reg, out_ins_reg, out_play_reg, out_loss_reg;

    // table memory
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [SEQ_W-1:0]  rd_seq;
    logic [TS_W-1:0]   rd_ts;
    logic [HND_W-1:0]  rd_hnd;
    logic [LEN_W-1:0]  rd_len;

    logic [MS_W-1:0]   eff_frame;
    logic [SEQ_W-1:0]  seq_diff;
    logic [SEQ_W-1:0]  key;
    logic [TIME_W-1:0] jit_abs;
    logic [48:0]       ewma_sum;
    logic [18:0]       tgt_sum;
    logic              scan_issue;
    logic              chk_used;

    assign eff_frame = (frame_reg == '0) ? FRAME_DEFAULT : frame_reg;
    assign seq_diff = in_seq_reg - exp_seq_reg;
    assign key = (in_cmd_reg == CMD_INSERT) ? in_seq_reg : exp_seq_reg;
    assign {rd_seq, rd_ts, rd_hnd, rd_len} = ram_rdata;
    assign scan_issue = (op == OP_SCAN) && (scan_idx_reg < SCAN_END);
    assign chk_used = (op == OP_SCAN) && chk_vld_reg && valid_reg[chk_idx_reg];

    assign jit_abs = (delta_reg >= TIME_W'(eff_frame)) ? delta_reg - TIME_W'(eff_frame)
                                                       : TIME_W'(eff_frame) - delta_reg;
    assign ewma_sum = 49'(prod_a_reg) + {5'd0, prod_b_reg, 16'd0} + 49'd32768;
    assign tgt_sum = {9'd0, min_tgt_reg} + {1'b0, smooth_reg[31:14]};

    assign flags.is_insert = (in_cmd_reg == CMD_INSERT);
    assign flags.is_tick = (in_cmd_reg == CMD_TICK);
    assign flags.is_flush = (in_cmd_reg == CMD_FLUSH);
    assign flags.len_zero = (in_len_reg == '0);
    assign flags.late = started_reg && seq_diff[SEQ_W-1];
    assign flags.due = started_reg && ({1'b0, in_now_reg} >= next_due_reg);
    assign flags.scan_done = chk_vld_reg && (chk_idx_reg == LAST_IDX);
    assign flags.hit = hit_vld_reg;

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = free_idx_reg;
        if (op == OP_INS_COMMIT) begin
            if (hit_vld_reg) begin
                ram_we = 1'b1;
                ram_waddr = hit_idx_reg;
            end else if (free_vld_reg) begin
                ram_we = 1'b1;
            end else if (min_vld_reg && (min_seq_reg < in_seq_reg)) begin
                ram_we = 1'b1;
                ram_waddr = min_idx_reg;
            end
        end
    end

    assign ram_wdata = {in_seq_reg, in_ts_reg, in_hnd_reg, in_len_reg};
    assign ram_raddr = (op == OP_PLAY_READ) ? hit_idx_reg : scan_idx_reg[IDX_W-1:0];

    ajb_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= FRAME_DEFAULT;
            min_tgt_reg <= MIN_TARGET_RESET;
            max_tgt_reg <= MAX_TARGET_RESET;
            started_reg <= 1'b0;
            last_vld_reg <= 1'b0;
            exp_seq_reg <= '0;
            exp_ts_reg <= '0;
            next_due_reg <= '0;
            last_arr_reg <= '0;
            smooth_reg <= '0;
            target_reg <= MIN_TARGET_RESET;
            valid_reg <= '0;
            occ_reg <= '0;
            drop_reg <= '0;
            ins_reg <= '0;
            play_reg <= '0;
            loss_reg <= '0;
            scan_idx_reg <= '0;
            chk_vld_reg <= 1'b0;
            hit_vld_reg <= 1'b0;
            free_vld_reg <= 1'b0;
            min_vld_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_FRAME: frame_reg <= cfg_data;
                    REG_MIN_TARGET: min_tgt_reg <= cfg_data;
                    REG_MAX_TARGET: max_tgt_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (op)
                OP_LATCH: begin
                    scan_idx_reg <= '0;
                    chk_vld_reg <= 1'b0;
                    hit_vld_reg <= 1'b0;
                    free_vld_reg <= 1'b0;
                    min_vld_reg <= 1'b0;
                end
                OP_DROP: drop_reg <= drop_reg + 1'b1;
                OP_FLUSH: begin
                    started_reg <= 1'b0;
                    last_vld_reg <= 1'b0;
                    exp_seq_reg <= '0;
                    exp_ts_reg <= '0;
                    next_due_reg <= '0;
                    last_arr_reg <= '0;
                    smooth_reg <= '0;
                    target_reg <= min_tgt_reg;
                    valid_reg <= '0;
                    occ_reg <= '0;
                    drop_reg <= '0;
                    ins_reg <= '0;
                    play_reg <= '0;
                    loss_reg <= '0;
                end
                OP_J4: begin
                    if (last_vld_reg) begin
                        smooth_reg <= (smooth_reg == '0) ? {jit_reg, 16'd0} : ewma_sum[47:16];
                    end
                end
                OP_J5: begin
                    if (last_vld_reg) begin
                        target_reg <= (tgt_sum > {9'd0, max_tgt_reg}) ? max_tgt_reg
                                                                     : tgt_sum[MS_W-1:0];
                    end
                    last_arr_reg <= in_now_reg;
                    last_vld_reg <= 1'b1;
                end
                OP_SCAN: begin
                    chk_vld_reg <= scan_issue;
                    if (scan_issue) begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    if (chk_vld_reg) begin
                        if (valid_reg[chk_idx_reg]) begin
                            if (rd_seq == key) begin
                                hit_vld_reg <= 1'b1;
                            end
                            if (!min_vld_reg || (rd_seq < min_seq_reg)) begin
                                min_vld_reg <= 1'b1;
                            end
                        end else if (!free_vld_reg) begin
                            free_vld_reg <= 1'b1;
                        end
                    end
                end
                OP_INS_COMMIT: begin
                    if (hit_vld_reg) begin
                        valid_reg[hit_idx_reg] <= 1'b1;
                    end else if (free_vld_reg) begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        occ_reg <= occ_reg + 1'b1;
                    end else begin
                        drop_reg <= drop_reg + 1'b1;
                    end
                    if (!started_reg) begin
                        started_reg <= 1'b1;
                        exp_seq_reg <= in_seq_reg;
                        exp_ts_reg <= in_ts_reg;
                        next_due_reg <= {1'b0, in_now_reg} + DUE_W'(target_reg);
                    end
                    ins_reg <= ins_reg + 1'b1;
                end
                OP_PLAY_COMMIT: begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                    occ_reg <= occ_reg - 1'b1;
                    play_reg <= play_reg + 1'b1;
                    exp_seq_reg <= exp_seq_reg + 1'b1;
                    exp_ts_reg <= exp_ts_reg + TS_W'(eff_frame);
                    next_due_reg <= next_due_reg + DUE_W'(eff_frame);
                end
                OP_CONCEAL: begin
                    loss_reg <= loss_reg + 1'b1;
                    exp_seq_reg <= exp_seq_reg + 1'b1;
                    exp_ts_reg <= exp_ts_reg + TS_W'(eff_frame);
                    next_due_reg <= next_due_reg + DUE_W'(eff_frame);
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (op)
            OP_LATCH: begin
                in_cmd_reg <= s_command;
                in_seq_reg <= s_seq;
                in_ts_reg <= s_timestamp;
                in_hnd_reg <= s_payload_handle;
                in_len_reg <= s_payload_length;
                in_now_reg <= s_time_ms;
                res_status_reg <= RES_NOT_DUE;
                res_seq_reg <= '0;
                res_ts_reg <= '0;
                res_hnd_reg <= '0;
                res_len_reg <= '0;
            end
            OP_EMPTY: res_status_reg <= RES_EMPTY;
            OP_DROP: res_status_reg <= RES_LATE;
            OP_J1: delta_reg <= (in_now_reg > last_arr_reg) ? in_now_reg - last_arr_reg : '0;
            OP_J2: jit_reg <= (jit_abs > TIME_W'(16'hFFFF)) ? 16'hFFFF : jit_abs[15:0];
            OP_J3: begin
                prod_a_reg <= smooth_reg * EWMA_KEEP;
                prod_b_reg <= jit_reg * EWMA_GAIN;
            end
            OP_SCAN: begin
                chk_idx_reg <= scan_idx_reg[IDX_W-1:0];
                if (chk_vld_reg) begin
                    if (valid_reg[chk_idx_reg]) begin
                        if (rd_seq == key) begin
                            hit_idx_reg <= chk_idx_reg;
                        end
                        if (!min_vld_reg || (rd_seq < min_seq_reg)) begin
                            min_idx_reg <= chk_idx_reg;
                            min_seq_reg <= rd_seq;
                        end
                    end else if (!free_vld_reg) begin
                        free_idx_reg <= chk_idx_reg;
                    end
                end
            end
            OP_INS_COMMIT: res_status_reg <= RES_INSERTED;
            OP_PLAY_COMMIT: begin
                res_status_reg <= RES_PLAYED;
                res_seq_reg <= exp_seq_reg;
                res_ts_reg <= rd_ts;
                res_hnd_reg <= rd_hnd;
                res_len_reg <= rd_len;
            end
            OP_CONCEAL: begin
                res_status_reg <= RES_CONCEALED;
                res_seq_reg <= exp_seq_reg;
                res_ts_reg <= exp_ts_reg;
            end
            OP_LOAD_OUT: begin
                out_status_reg <= res_status_reg;
                out_seq_reg <= res_seq_reg;
                out_ts_reg <= res_ts_reg;
                out_hnd_reg <= res_hnd_reg;
                out_len_reg <= res_len_reg;
                out_target_reg <= target_reg;
                out_occ_reg <= occ_reg;
                out_drop_reg <= drop_reg;
                out_ins_reg <= ins_reg;
                out_play_reg <= play_reg;
                out_loss_reg <= loss_reg;
            end
            default: ;
        endcase
    end

    assign m_status = out_status_reg;
    assign m_seq_out = out_seq_reg;
    assign m_timestamp_out = out_ts_reg;
    assign m_payload_handle_out = out_hnd_reg;
    assign m_payload_length_out = out_len_reg;
    assign m_target_ms = out_target_reg;
    assign m_depth = out_occ_reg;
    assign m_late_drop_count = out_drop_reg;
    assign m_inserted_count = out_ins_reg;
    assign m_played_count = out_play_reg;
    assign m_lost_count = out_loss_reg;

    `AJB_ASSERT(a_occ_matches_valid, $countones(valid_reg) == occ_reg, "occupancy mismatch")
    `AJB_ASSERT(a_occ_bound, occ_reg <= OCC_FULL, "occupancy above depth")
    `AJB_ASSERT(a_flush_clears, op == OP_FLUSH |=> valid_reg == '0 && occ_reg == '0, "flush left entries")
    `AJB_ASSERT(a_scan_only_valid, chk_used |-> chk_vld_reg, "scan used stale read")
endmodule

@@ design/adaptive_jitter_buffer.sv @@
// adaptive jitter buffer: one result per transaction, processed sequentially
// insert: decode, five jitter estimator steps, table scan, commit, then the result is loaded
// due tick: decode, table scan, and one table read when the frame is present
// empty, late, not due, unused and flush: decode only, then the result is loaded
// synchronous active low reset restores configuration, playout state, counters and valid bits; no table clearing pass
`timescale 1ns / 1ps
module adaptive_jitter_buffer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ajb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ajb_pkg::MS_W-1:0]      cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [ajb_pkg::SEQ_W-1:0]     s_seq,
    input  logic [ajb_pkg::TS_W-1:0]      s_timestamp,
    input  logic [ajb_pkg::HND_W-1:0]     s_payload_handle,
    input  logic [ajb_pkg::LEN_W-1:0]     s_payload_length,
    input  logic [ajb_pkg::TIME_W-1:0]    s_time_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [ajb_pkg::SEQ_W-1:0]     m_seq_out,
    output logic [ajb_pkg::TS_W-1:0]      m_timestamp_out,
    output logic [ajb_pkg::HND_W-1:0]     m_payload_handle_out,
    output logic [ajb_pkg::LEN_W-1:0]     m_payload_length_out,
    output logic [ajb_pkg::MS_W-1:0]      m_target_ms,
    output logic [ajb_pkg::OCC_W-1:0]     m_depth,
    output logic [ajb_pkg::CNT_W-1:0]     m_late_drop_count,
    output logic [ajb_pkg::CNT_W-1:0]     m_inserted_count,
    output logic [ajb_pkg::CNT_W-1:0]     m_played_count,
    output logic [ajb_pkg::CNT_W-1:0]     m_lost_count
);
    import ajb_pkg::*;

    ajb_op_t    op;
    ajb_flags_t flags;

    assign cfg_ready = 1'b1;

    ajb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .flags   (flags),
        .op      (op)
    );

    ajb_dp u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .op                   (op),
        .flags                (flags),
        .cfg_valid            (cfg_valid),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_command            (s_command),
        .s_seq                (s_seq),
        .s_timestamp          (s_timestamp),
        .s_payload_handle     (s_payload_handle),
        .s_payload_length     (s_payload_length),
        .s_time_ms            (s_time_ms),
        .m_status             (m_status),
        .m_seq_out            (m_seq_out),
        .m_timestamp_out      (m_timestamp_out),
        .m_payload_handle_out (m_payload_handle_out),
        .m_payload_length_out (m_payload_length_out),
        .m_target_ms          (m_target_ms),
        .m_depth              (m_depth),
        .m_late_drop_count    (m_late_drop_count),
        .m_inserted_count     (m_inserted_count),
        .m_played_count       (m_played_count),
        .m_lost_count         (m_lost_count)
    );
endmodule

@@ dv/testbench.sv @@
// self-checking testbench for adaptive_jitter_buffer: directed, overflow, config, backpressure and random tests
// keeps its own model of the buffer and compares every result transaction field by field
// depends on design/ajb_pkg.sv and design/adaptive_jitter_buffer.sv
`timescale 1ns / 1ps
module testbench;
    import ajb_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]        cmd;
        logic [SEQ_W-1:0]  seq;
        logic [TS_W-1:0]   ts;
        logic [HND_W-1:0]  handle;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] now_ms;
    } packet_t;

    typedef struct {
        logic [2:0]       status;
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0]  ts;
        logic [HND_W-1:0] handle;
        logic [LEN_W-1:0] len;
        logic [MS_W-1:0]  target;
        logic [OCC_W-1:0] depth;
        logic [CNT_W-1:0] drops;
        logic [CNT_W-1:0] inserts;
        logic [CNT_W-1:0] plays;
        logic [CNT_W-1:0] losses;
    } frame_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MS_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_command = '0;
    logic [SEQ_W-1:0] s_seq = '0;
    logic [TS_W-1:0] s_timestamp = '0;
    logic [HND_W-1:0] s_payload_handle = '0;
    logic [LEN_W-1:0] s_payload_length = '0;
    logic [TIME_W-1:0] s_time_ms = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_status;
    logic [SEQ_W-1:0] m_seq_out;
    logic [TS_W-1:0] m_timestamp_out;
    logic [HND_W-1:0] m_payload_handle_out;
    logic [LEN_W-1:0] m_payload_length_out;
    logic [MS_W-1:0] m_target_ms;
    logic [OCC_W-1:0] m_depth;
    logic [CNT_W-1:0] m_late_drop_count;
    logic [CNT_W-1:0] m_inserted_count;
    logic [CNT_W-1:0] m_played_count;
    logic [CNT_W-1:0] m_lost_count;

    adaptive_jitter_buffer dut (.*);

    // model state
    logic [MS_W-1:0] frame_reg, min_reg, max_reg;
    bit started, arrival_seen;
    logic [SEQ_W-1:0] exp_seq;
    logic [TS_W-1:0] exp_ts;
    logic [DUE_W-1:0] next_due;
    logic [TIME_W-1:0] last_arrival;
    logic [31:0] jitter_q16;
    logic [MS_W-1:0] target;
    bit slot_valid [DEPTH];
    logic [SEQ_W-1:0] slot_seq [DEPTH];
    logic [TS_W-1:0] slot_ts [DEPTH];
    logic [HND_W-1:0] slot_handle [DEPTH];
    logic [LEN_W-1:0] slot_len [DEPTH];
    logic [OCC_W-1:0] occupancy;
    logic [CNT_W-1:0] drops, inserts, plays, losses;

    frame_result_t expected_frames[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit recv_hold = 0;
    int cycles = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [MS_W-1:0] eff_frame();
        return (frame_reg == 0) ? MS_W'(20) : frame_reg;
    endfunction

    function automatic void clear_buffer();
        started = 0;
        arrival_seen = 0;
        exp_seq = '0;
        exp_ts = '0;
        next_due = '0;
        last_arrival = '0;
        jitter_q16 = '0;
        target = min_reg;
        foreach (slot_valid[i]) slot_valid[i] = 0;
        occupancy = '0;
        drops = '0;
        inserts = '0;
        plays = '0;
        losses = '0;
    endfunction

    function automatic void track_jitter(logic [TIME_W-1:0] now_ms);
        longint unsigned delta, j, sum, t;
        if (arrival_seen) begin
            delta = (now_ms > last_arrival) ? now_ms - last_arrival : 0;
            j = (delta >= eff_frame()) ? delta - eff_frame() : eff_frame() - delta;
            if (j > 65535) j = 65535;
            if (jitter_q16 == 0) begin
                jitter_q16 = 32'(j << 16);
            end else begin
                sum = longint'(jitter_q16) * 62259 + (j << 16) * 3277 + 32768;
                jitter_q16 = 32'(sum >> 16);
            end
            t = longint'(min_reg) + (jitter_q16 >> 14);
            if (t > max_reg) t = max_reg;
            target = MS_W'(t);
        end
        last_arrival = now_ms;
        arrival_seen = 1;
    endfunction

    function automatic logic [2:0] insert_packet(packet_t p);
        int hit, free_slot, min_slot;
        hit = -1;
        free_slot = -1;
        min_slot = -1;
        if (p.len == 0) return RES_EMPTY;
        if (started && ((p.seq - exp_seq) & 16'hFFFF) >= 16'h8000) begin
            drops++;
            return RES_LATE;
        end
        track_jitter(p.now_ms);
        for (int i = 0; i < DEPTH; i++) begin
            if (slot_valid[i]) begin
                if (slot_seq[i] == p.seq) hit = i;
                if (min_slot < 0 || slot_seq[i] < slot_seq[min_slot]) min_slot = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit < 0 && free_slot < 0) begin
            drops++;
            if (min_slot >= 0 && slot_seq[min_slot] < p.seq) hit = min_slot;
        end else if (hit < 0) begin
            hit = free_slot;
            occupancy++;
        end
        if (hit >= 0) begin
            slot_valid[hit] = 1;
            slot_seq[hit] = p.seq;
            slot_ts[hit] = p.ts;
            slot_handle[hit] = p.handle;
            slot_len[hit] = p.len;
        end
        if (!started) begin
            started = 1;
            exp_seq = p.seq;
            exp_ts = p.ts;
            next_due = DUE_W'(p.now_ms) + DUE_W'(target);
        end
        inserts++;
        return RES_INSERTED;
    endfunction

    function automatic frame_result_t predict_frame(packet_t p);
        frame_result_t r;
        int hit;
        r = '{status: RES_NOT_DUE, default: '0};
        if (p.cmd == CMD_INSERT) begin
            r.status = insert_packet(p);
        end else if (p.cmd == CMD_TICK) begin
            if (started && DUE_W'(p.now_ms) >= next_due) begin
                hit = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (slot_valid[i] && slot_seq[i] == exp_seq) hit = i;
                r.seq = exp_seq;
                r.ts = exp_ts;
                if (hit >= 0) begin
                    r.status = RES_PLAYED;
                    r.ts = slot_ts[hit];
                    r.handle = slot_handle[hit];
                    r.len = slot_len[hit];
                    slot_valid[hit] = 0;
                    occupancy--;
                    plays++;
                end else begin
                    r.status = RES_CONCEALED;
                    losses++;
                end
                exp_seq++;
                exp_ts += eff_frame();
                next_due += eff_frame();
            end
        end else if (p.cmd == CMD_FLUSH) begin
            clear_buffer();
        end
        r.target = target;
        r.depth = occupancy;
        r.drops = drops;
        r.inserts = inserts;
        r.plays = plays;
        r.losses = losses;
        return r;
    endfunction

    always @(posedge aclk) begin
        frame_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                e = expected_frames.pop_front();
                if (m_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_status); errors++;
                end
                if (m_seq_out !== e.seq) begin
                    $error("seq_out exp %0d got %0d", e.seq, m_seq_out); errors++;
                end
                if (m_timestamp_out !== e.ts) begin
                    $error("timestamp_out exp %0d got %0d", e.ts, m_timestamp_out); errors++;
                end
                if (m_payload_handle_out !== e.handle) begin
                    $error("payload_handle_out exp %0d got %0d", e.handle,
                           m_payload_handle_out);
                    errors++;
                end
                if (m_payload_length_out !== e.len) begin
                    $error("payload_length_out exp %0d got %0d", e.len,
                           m_payload_length_out);
                    errors++;
                end
                if (m_target_ms !== e.target) begin
                    $error("target_ms exp %0d got %0d", e.target, m_target_ms); errors++;
                end
                if (m_depth !== e.depth) begin
                    $error("depth exp %0d got %0d", e.depth, m_depth); errors++;
                end
                if (m_late_drop_count !== e.drops) begin
                    $error("late_drop_count exp %0d got %0d", e.drops, m_late_drop_count);
                    errors++;
                end
                if (m_inserted_count !== e.inserts) begin
                    $error("inserted_count exp %0d got %0d", e.inserts, m_inserted_count);
                    errors++;
                end
                if (m_played_count !== e.plays) begin
                    $error("played_count exp %0d got %0d", e.plays, m_played_count); errors++;
                end
                if (m_lost_count !== e.losses) begin
                    $error("lost_count exp %0d got %0d", e.losses, m_lost_count); errors++;
                end
            end
        end
    end

    task automatic send_packet(packet_t p);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= p.cmd;
        s_seq <= p.seq;
        s_timestamp <= p.ts;
        s_payload_handle <= p.handle;
        s_payload_length <= p.len;
        s_time_ms <= p.now_ms;
        do @(posedge aclk); while (!s_ready);
        expected_frames.push_back(predict_frame(p));
    endtask

    task automatic send_cmd(logic [1:0] cmd, logic [SEQ_W-1:0] seq, logic [TS_W-1:0] ts,
                            logic [HND_W-1:0] handle, logic [LEN_W-1:0] len,
                            logic [TIME_W-1:0] now_ms);
        packet_t p;
        p = '{cmd: cmd, seq: seq, ts: ts, handle: handle, len: len, now_ms: now_ms};
        send_packet(p);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MS_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FRAME:      frame_reg = value;
            REG_MIN_TARGET: min_reg = value;
            REG_MAX_TARGET: max_reg = value;
            default: ;
        endcase
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    task automatic test_directed();
        logic [TIME_W-1:0] t;
        send_cmd(CMD_TICK, 16'd5, '1, '1, '1, '1);
        send_cmd(CMD_INSERT, 16'hFFFF, '1, '1, '0, 100);
        send_cmd(CMD_INSERT, 16'hFFFE, 32'hFFFF_FFF0, 16'hFFFF, 12'hFFF, 1000);
        send_cmd(CMD_INSERT, 16'hFFFF, 32'h0, 16'h0, 12'd1, 1020);
        send_cmd(CMD_INSERT, 16'hFFFF, 32'h1234, 16'hABCD, 12'd160, 1035);
        send_cmd(CMD_INSERT, 16'h7FFD, 32'h5, 16'h5, 12'd5, 1036);
        send_cmd(CMD_INSERT, 16'h7FFE, 32'h6, 16'h6, 12'd6, 1037);
        send_cmd(CMD_INSERT, 16'h0001, 32'h7, 16'h7, 12'd7, 9000);
        send_cmd(CMD_INSERT, 16'h0000, 32'h8, 16'h8, 12'd8, 9000);
        send_cmd(CMD_TICK, '0, '0, '0, '0, 1000);
        send_cmd(CMD_UNUSED, '1, '1, '1, '1, '1);
        for (int i = 0; i < 5; i++) send_cmd(CMD_TICK, '0, '0, '0, '0, 20000);
        send_cmd(CMD_FLUSH, '1, '1, '1, '1, '1);
        t = TIME_W'(47'h7FFF_FFFF_FF00);
        send_cmd(CMD_INSERT, 16'h8000, 32'hAAAA_5555, 16'h5555, 12'hAAA, t);
        send_cmd(CMD_INSERT, 16'h8001, 32'h5555_AAAA, 16'hAAAA, 12'h555, '1);
        send_cmd(CMD_TICK, '0, '0, '0, '0, '1);
        send_cmd(CMD_FLUSH, '0, '0, '0, '0, '0);
    endtask

    task automatic test_overflow();
        logic [TIME_W-1:0] t;
        t = 5000;
        send_cmd(CMD_INSERT, 16'd100, 32'd0, 16'd1, 12'd10, t);
        for (int i = 1; i < 66; i++) begin
            t += eff_frame();
            send_cmd(CMD_INSERT, 16'(100 + i), $urandom, 16'($urandom), 12'd10, t);
        end
        // new key below every stored key is thrown away itself
        send_cmd(CMD_INSERT, 16'd101, $urandom, 16'($urandom), 12'd11, t + 20);
        send_cmd(CMD_INSERT, 16'd300, $urandom, 16'($urandom), 12'd12, t + 40);
        for (int i = 0; i < 4; i++) send_cmd(CMD_TICK, '0, '0, '0, '0, t + 400);
        send_cmd(CMD_FLUSH, '0, '0, '0, '0, '0);
    endtask

    task automatic run_stream(int n);
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0] ts;
        logic [TIME_W-1:0] t;
        int pick, jit;
        seq = 16'($urandom);
        ts = $urandom;
        t = ($urandom_range(3) == 0) ? rand_time() >> 1 : TIME_W'($urandom);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                jit = $urandom_range(9) == 0 ? $urandom_range(2000) : $urandom_range(30);
                t += (jit > 10) ? eff_frame() + jit - 10 : eff_frame() - (eff_frame() > jit ?
                                                                              jit : 0);
                if ($urandom_range(9) == 0) seq += 16'($urandom_range(3));
                send_cmd(CMD_INSERT, seq, ts, 16'($urandom), 12'($urandom_range(1, 4095)), t);
                seq++;
                ts += eff_frame();
            end else if (pick < 90) begin
                send_cmd(CMD_TICK, 16'($urandom), $urandom, 16'($urandom), 12'($urandom),
                         t + $urandom_range(200));
            end else if (pick < 94) begin
                send_cmd(CMD_INSERT, seq - 16'($urandom_range(1, 40)), $urandom,
                         16'($urandom), 12'($urandom_range(1, 4095)), t);
            end else if (pick < 96) begin
                send_cmd(CMD_INSERT, 16'($urandom), $urandom, 16'($urandom),
                         12'($urandom_range(0, 1)), t);
            end else if (pick < 98) begin
                send_cmd(CMD_UNUSED, 16'($urandom), $urandom, 16'($urandom), 12'($urandom),
                         rand_time());
            end else begin
                send_cmd(CMD_FLUSH, 16'($urandom), $urandom, 16'($urandom), 12'($urandom),
                         rand_time());
            end
        end
    endtask

    task automatic test_config();
        write_reg(REG_FRAME, 10'd0);
        write_reg(REG_MIN_TARGET, 10'd200);
        write_reg(REG_MAX_TARGET, 10'd100);
        run_stream(40);
        write_reg(REG_FRAME, 10'd1000);
        write_reg(REG_MIN_TARGET, 10'd0);
        write_reg(REG_MAX_TARGET, 10'd1000);
        run_stream(40);
        write_reg(REG_FRAME, 10'd1);
        write_reg(REG_MIN_TARGET, 10'd1000);
        run_stream(30);
        write_reg(REG_FRAME, 10'd20);
        write_reg(REG_MIN_TARGET, 10'd60);
        write_reg(REG_MAX_TARGET, 10'd180);
    endtask

    task automatic test_random();
        int idle_mix [4][2] = '{'{0, 0}, '{67, 0}, '{0, 67}, '{37, 37}};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_mix[ph][0];
            recv_stall_pct = idle_mix[ph][1];
            write_reg(REG_FRAME, 10'($urandom_range(5, 40)));
            run_stream(125);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1;
                repeat (600) @(posedge aclk);
                recv_hold = 0;
            end
        join_none
        run_stream(20);
    endtask

    initial begin
        frame_reg = FRAME_DEFAULT;
        min_reg = MIN_TARGET_RESET;
        max_reg = MAX_TARGET_RESET;
        clear_buffer();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow();
        test_config();
        test_backpressure();
        test_random();
        wait_idle();
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_frames.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
